// ===== hw/rtl/stte_pkg.sv =====
// Package: shared constants and types of the square tile transform engine.
`timescale 1ns / 1ps
package stte_pkg;
  localparam int unsigned MaxSide = 16;
  localparam int unsigned CoordW  = 4;
  localparam int unsigned AddrW   = 2 * CoordW;
  localparam int unsigned SideW   = 5;
  localparam int unsigned PixW    = 8;

  typedef enum logic [2:0] {
    KIND_WRITE  = 3'd0,
    KIND_READ   = 3'd1,
    KIND_SWAP   = 3'd2,
    KIND_COLS   = 3'd3,
    KIND_MIRROR = 3'd4,
    KIND_TRANS  = 3'd5,
    KIND_ROT    = 3'd6,
    KIND_NBR    = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_RANGE  = 2'd1,
    ST_WINDOW = 2'd2,
    ST_SPARE  = 2'd3
  } status_e;

  // One pixel exchange request handed to the swap unit.
  typedef struct packed {
    logic             valid;
    logic [AddrW-1:0] addr_p;
    logic [AddrW-1:0] addr_q;
  } xchg_req_t;
endpackage

// ===== hw/rtl/stte_xchg.sv =====
// Module: tile memory with a read-modify-write exchange unit and a pixel port.
`timescale 1ns / 1ps
module stte_xchg import stte_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  xchg_req_t        req_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [PixW-1:0]  wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [PixW-1:0]  rd_data_o,
  output logic             busy_o
);
  logic [PixW-1:0] mem_q [MaxSide*MaxSide];
  logic [PixW-1:0] dat_p_q, dat_q_q;
  logic [AddrW-1:0] ap_q, aq_q;
  logic            ph_q;

  // Phase 0 reads both cells, phase 1 writes them back crossed.
  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      dat_p_q <= mem_q[req_i.addr_p];
      dat_q_q <= mem_q[req_i.addr_q];
      ap_q    <= req_i.addr_p;
      aq_q    <= req_i.addr_q;
    end else if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
    if (ph_q) begin
      mem_q[ap_q] <= dat_q_q;
      mem_q[aq_q] <= dat_p_q;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= 1'b0;
    end else begin
      ph_q <= req_i.valid;
    end
  end

  assign busy_o = ph_q;

  // A new exchange never starts during write-back.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q |-> !req_i.valid) else $error("exchange overlap");
  a_no_wr_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q |-> !wr_en_i) else $error("write during write-back");
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid |=> !req_i.valid) else $error("back to back exchange");
endmodule

// ===== hw/rtl/square_tile_transform_engine_core.sv =====
// Top level: square tile transform engine with stream ports and a config channel.
`timescale 1ns / 1ps
// Holds a square tile of bytes (side set by the cfg channel, saturated to 16)
// in one dual-port memory. Write, read and every rejected request are served
// without the exchange unit. All other kinds move pixels by exchanges in the
// exchange unit. Each exchange reads both cells, then writes them back
// crossed; a rotate is a transpose, then a mirror.
// Results sit in an output register. A new request is taken while a result
// waits there. The engine stalls only when the next result is ready before
// the waiting one is taken. The user must read cells only after they were
// written; the block itself does not enforce it. After reset the tile holds
// nothing defined.
module square_tile_transform_engine_core import stte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: kind[2:0], row_a[6:3], col_a[10:7], row_b[14:11], col_b[18:15],
  // pixel_in[26:19], zero fill [31:27]
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: pixel_out[7:0], status[9:8], zero fill [15:10]
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i
);
  localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_WALK = 3'd2,
                         S_OUT = 3'd3, S_ROTM = 3'd4;

  logic [2:0] st_q, st_d;
  logic [SideW-1:0] side_q;
  logic [SideW-1:0] n;
  logic [2:0] kind_q;
  logic [CoordW-1:0] ra_q, ca_q, rb_q, cb_q;
  logic [CoordW:0] i_q, i_d, j_q, j_d;
  logic [PixW-1:0] pix_q, rd_data;
  logic [1:0] stat_q, stat_d, ostat_q;
  logic ovalid_q, isread_q, isread_d;
  logic ld_out;
  logic busy;
  xchg_req_t req;
  logic wr_en, rd_en;
  logic [AddrW-1:0] wr_addr;
  logic [CoordW-1:0] ra, ca, rb, cb;
  logic [2:0] kind;
  logic acc;
  logic [SideW-1:0] dra, dca;
  logic [CoordW:0] ip, iq, jp, jq, jlim;
  logic walk_done;

  assign kind = s_axis_tdata[2:0];
  assign ra = s_axis_tdata[6:3];
  assign ca = s_axis_tdata[10:7];
  assign rb = s_axis_tdata[14:11];
  assign cb = s_axis_tdata[18:15];
  assign n = (side_q > SideW'(MaxSide)) ? SideW'(MaxSide) : side_q;

  assign s_axis_tready = (st_q == S_IDLE);
  assign acc = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  // Load the output register once the previous result is gone or leaving
  assign ld_out = (st_q == S_OUT) && (!ovalid_q || m_axis_tready);

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) side_q <= SideW'(MaxSide);
    else if (cfg_valid_i) side_q <= cfg_data_i;
  end

  // Range and window checks on the incoming request
  logic bad_a, bad_b, bad_ca, bad_cb, border, overl;
  always_comb begin
    bad_a  = ({1'b0, ra} >= n) || ({1'b0, ca} >= n);
    bad_b  = ({1'b0, rb} >= n) || ({1'b0, cb} >= n);
    bad_ca = {1'b0, ca} >= n;
    bad_cb = {1'b0, cb} >= n;
    border = (ra == '0) || (ca == '0) || (rb == '0) || (cb == '0) ||
             ({1'b0, ra} + 5'd1 == n) || ({1'b0, ca} + 5'd1 == n) ||
             ({1'b0, rb} + 5'd1 == n) || ({1'b0, cb} + 5'd1 == n);
    dra = (ra > rb) ? SideW'(ra - rb) : SideW'(rb - ra);
    dca = (ca > cb) ? SideW'(ca - cb) : SideW'(cb - ca);
    overl = (dra < 5'd3) && (dca < 5'd3);
  end

  // Exchange pair for the current walk position
  always_comb begin
    ip = i_q; jp = j_q; iq = j_q; jq = i_q; jlim = n / 5'd2;
    walk_done = 1'b1;
    case (kind_q)
      KIND_SWAP: begin
        ip = {1'b0, ra_q}; jp = {1'b0, ca_q}; iq = {1'b0, rb_q}; jq = {1'b0, cb_q};
        walk_done = (i_q != '0);
      end
      KIND_COLS: begin
        ip = i_q; jp = {1'b0, ca_q}; iq = i_q; jq = {1'b0, cb_q};
        walk_done = (i_q >= n);
      end
      KIND_MIRROR: begin
        ip = i_q; jp = j_q; iq = i_q; jq = n - 5'd1 - j_q;
        walk_done = (i_q >= n) || (jlim == '0);
      end
      KIND_TRANS, KIND_ROT: begin
        ip = i_q; jp = j_q; iq = j_q; jq = i_q;
        walk_done = (i_q >= n);
      end
      KIND_NBR: begin
        ip = {1'b0, ra_q} + i_q - 5'd1; jp = {1'b0, ca_q} + j_q - 5'd1;
        iq = {1'b0, rb_q} + i_q - 5'd1; jq = {1'b0, cb_q} + j_q - 5'd1;
        walk_done = (i_q >= 5'd3);
      end
      default: walk_done = 1'b1;
    endcase
  end

  // Next walk position
  always_comb begin
    i_d = i_q; j_d = j_q;
    case (kind_q)
      KIND_SWAP: i_d = i_q + 5'd1;
      KIND_COLS: i_d = i_q + 5'd1;
      KIND_MIRROR: begin
        if (j_q + 5'd1 >= jlim) begin j_d = '0; i_d = i_q + 5'd1; end
        else j_d = j_q + 5'd1;
      end
      KIND_TRANS, KIND_ROT: begin
        if (j_q + 5'd1 >= i_q) begin j_d = '0; i_d = i_q + 5'd1; end
        else j_d = j_q + 5'd1;
      end
      KIND_NBR: begin
        if (j_q == 5'd2) begin j_d = '0; i_d = i_q + 5'd1; end
        else if (i_q == 5'd1 && j_q == 5'd0) j_d = 5'd2;
        else j_d = j_q + 5'd1;
      end
      default: i_d = i_q;
    endcase
  end

  // Sequencer
  always_comb begin
    st_d = st_q; stat_d = stat_q; isread_d = isread_q;
    req = '0; wr_en = 1'b0; rd_en = 1'b0;
    wr_addr = {ra, ca};
    case (st_q)
      S_IDLE: if (acc) begin
        isread_d = 1'b0; stat_d = ST_DONE;
        case (kind)
          KIND_WRITE: begin
            if (bad_a) stat_d = ST_RANGE; else wr_en = 1'b1;
            st_d = S_OUT;
          end
          KIND_READ: begin
            if (bad_a) begin stat_d = ST_RANGE; st_d = S_OUT; end
            else begin rd_en = 1'b1; isread_d = 1'b1; st_d = S_RD; end
          end
          KIND_SWAP: begin
            if (bad_a || bad_b) begin stat_d = ST_RANGE; st_d = S_OUT; end
            else st_d = S_WALK;
          end
          KIND_COLS: begin
            if (bad_ca || bad_cb) begin stat_d = ST_RANGE; st_d = S_OUT; end
            else st_d = S_WALK;
          end
          KIND_NBR: begin
            if (bad_a || bad_b) begin stat_d = ST_RANGE; st_d = S_OUT; end
            else if (border || overl) begin stat_d = ST_WINDOW; st_d = S_OUT; end
            else st_d = S_WALK;
          end
          default: st_d = S_WALK;
        endcase
      end
      S_RD: st_d = S_OUT;
      S_WALK, S_ROTM: if (!busy) begin
        if (walk_done) begin
          st_d = (kind_q == KIND_ROT && st_q == S_WALK) ? S_ROTM : S_OUT;
        end else begin
          req.valid  = 1'b1;
          req.addr_p = {ip[CoordW-1:0], jp[CoordW-1:0]};
          req.addr_q = {iq[CoordW-1:0], jq[CoordW-1:0]};
        end
      end
      // Hold until the output register is free
      S_OUT: if (ld_out) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  // Mirror pass after transpose completes a rotation
  logic [2:0] kind_eff;
  assign kind_eff = (st_d == S_ROTM && st_q == S_WALK) ? KIND_MIRROR : kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; ovalid_q <= 1'b0;
      i_q <= '0; j_q <= '0; kind_q <= KIND_WRITE;
      ra_q <= '0; ca_q <= '0; rb_q <= '0; cb_q <= '0;
      stat_q <= ST_DONE; isread_q <= 1'b0;
      ostat_q <= ST_DONE; pix_q <= '0;
    end else begin
      st_q <= st_d; stat_q <= stat_d; isread_q <= isread_d;
      if (acc) begin
        kind_q <= kind; ra_q <= ra; ca_q <= ca; rb_q <= rb; cb_q <= cb;
        i_q <= (kind == KIND_TRANS || kind == KIND_ROT) ? 5'd1 : 5'd0;
        j_q <= '0;
      end else if (st_q == S_WALK && st_d == S_ROTM) begin
        kind_q <= kind_eff; i_q <= '0; j_q <= '0;
      end else if (req.valid) begin
        i_q <= i_d; j_q <= j_d;
      end
      if (ld_out) begin
        ovalid_q <= 1'b1;
        ostat_q  <= stat_q;
        pix_q    <= isread_q ? rd_data : '0;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  stte_xchg u_xchg (
    .clk_i, .rst_ni, .req_i(req), .wr_en_i(wr_en), .wr_addr_i(wr_addr),
    .wr_data_i(s_axis_tdata[26:19]), .rd_en_i(rd_en), .rd_addr_i({ra, ca}),
    .rd_data_o(rd_data), .busy_o(busy)
  );

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {6'd0, ostat_q, pix_q};

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> !busy) else $error("request taken during exchange");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !m_axis_tready) |=> (ovalid_q && $stable(m_axis_tdata)))
    else $error("result dropped or changed while waiting");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> ostat_q != ST_SPARE) else $error("bad status");
endmodule

// ===== tb/tb.sv =====
// Testbench: stream-driven check of the square tile transform engine against a tile predictor.
`timescale 1ns / 1ps
module tb import stte_pkg::*;;

  // One request: fields from the top bit down so that {zero fill, request} is tdata.
  typedef struct packed {
    logic [7:0] pix;
    logic [3:0] cb;
    logic [3:0] rb;
    logic [3:0] ca;
    logic [3:0] ra;
    kind_e      kind;
  } tile_cmd_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] pixel;
  } tile_res_t;

  localparam int unsigned StoreDepth = MaxSide * MaxSide;
  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned DrainCycles = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i = '0;

  // Store 0 holds predicted pixels, store 1 marks cells that hold a written value.
  logic [7:0]  tile_mem [2][StoreDepth];
  int          pred_side;
  int          gen_side;
  tile_cmd_t   pending_q[$];
  tile_res_t   result_q[$];
  int          snd_idle;
  int          rcv_stall;
  int          errors = 0;
  int          cycles = 0;
  logic        in_took = 1'b0;

  square_tile_transform_engine_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one request to store sel at side n and return its result.
  function automatic tile_res_t tile_apply(int sel, tile_cmd_t c, int n);
    tile_res_t  r;
    logic [7:0] tmp [StoreDepth];
    logic [7:0] hold;
    int         ra, ca, rb, cb, p, q, dr, dc;
    ra = c.ra; ca = c.ca; rb = c.rb; cb = c.cb;
    r.pixel = '0;
    r.status = ST_DONE;
    case (c.kind)
      KIND_WRITE, KIND_READ: begin
        if (ra >= n || ca >= n) r.status = ST_RANGE;
        else if (c.kind == KIND_WRITE) tile_mem[sel][ra*MaxSide+ca] = c.pix;
        else r.pixel = tile_mem[sel][ra*MaxSide+ca];
      end
      KIND_SWAP: begin
        if (ra >= n || ca >= n || rb >= n || cb >= n) r.status = ST_RANGE;
        else begin
          p = ra*MaxSide+ca; q = rb*MaxSide+cb;
          hold = tile_mem[sel][p]; tile_mem[sel][p] = tile_mem[sel][q];
          tile_mem[sel][q] = hold;
        end
      end
      KIND_COLS: begin
        if (ca >= n || cb >= n) r.status = ST_RANGE;
        else for (int i = 0; i < n; i++) begin
          p = i*MaxSide+ca; q = i*MaxSide+cb;
          hold = tile_mem[sel][p]; tile_mem[sel][p] = tile_mem[sel][q];
          tile_mem[sel][q] = hold;
        end
      end
      KIND_MIRROR: begin
        for (int i = 0; i < n; i++)
          for (int j = 0; j < n/2; j++) begin
            p = i*MaxSide+j; q = i*MaxSide+n-1-j;
            hold = tile_mem[sel][p]; tile_mem[sel][p] = tile_mem[sel][q];
            tile_mem[sel][q] = hold;
          end
      end
      KIND_TRANS: begin
        for (int i = 1; i < n; i++)
          for (int j = 0; j < i; j++) begin
            p = i*MaxSide+j; q = j*MaxSide+i;
            hold = tile_mem[sel][p]; tile_mem[sel][p] = tile_mem[sel][q];
            tile_mem[sel][q] = hold;
          end
      end
      KIND_ROT: begin
        for (int i = 0; i < n; i++)
          for (int j = 0; j < n; j++) tmp[i*MaxSide+j] = tile_mem[sel][(n-1-j)*MaxSide+i];
        for (int i = 0; i < n; i++)
          for (int j = 0; j < n; j++) tile_mem[sel][i*MaxSide+j] = tmp[i*MaxSide+j];
      end
      default: begin
        dr = (ra > rb) ? ra - rb : rb - ra;
        dc = (ca > cb) ? ca - cb : cb - ca;
        if (ra >= n || ca >= n || rb >= n || cb >= n) r.status = ST_RANGE;
        else if (ra == 0 || ca == 0 || ra == n-1 || ca == n-1 ||
                 rb == 0 || cb == 0 || rb == n-1 || cb == n-1 ||
                 (dr < 3 && dc < 3)) r.status = ST_WINDOW;
        else for (int i = -1; i <= 1; i++)
          for (int j = -1; j <= 1; j++)
            if (i != 0 || j != 0) begin
              p = (ra+i)*MaxSide+ca+j; q = (rb+i)*MaxSide+cb+j;
              hold = tile_mem[sel][p]; tile_mem[sel][p] = tile_mem[sel][q];
              tile_mem[sel][q] = hold;
            end
      end
    endcase
    return r;
  endfunction

  // Queue one request; a read of a never-written cell becomes a write of it.
  task automatic queue_cmd(kind_e k, int ra, int ca, int rb, int cb, int pix);
    tile_cmd_t c;
    c = '{pix: pix[7:0], cb: cb[3:0], rb: rb[3:0], ca: ca[3:0], ra: ra[3:0], kind: k};
    if (k == KIND_READ && ra < gen_side && ca < gen_side &&
        tile_mem[1][ra*MaxSide+ca] == 8'd0) c.kind = KIND_WRITE;
    pending_q.push_back(c);
    c.pix = 8'd1;
    void'(tile_apply(1, c, gen_side));
  endtask

  function automatic int pick_coord(int n);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 15);
    return $urandom_range(0, n-1);
  endfunction

  task automatic queue_random();
    int    w, ra, ca, rb, cb;
    kind_e k;
    w = $urandom_range(0, 99);
    k = (w < 22) ? KIND_WRITE : (w < 42) ? KIND_READ : (w < 54) ? KIND_SWAP :
        (w < 63) ? KIND_COLS : (w < 68) ? KIND_MIRROR : (w < 73) ? KIND_TRANS :
        (w < 78) ? KIND_ROT : KIND_NBR;
    ra = pick_coord(gen_side); ca = pick_coord(gen_side);
    rb = pick_coord(gen_side); cb = pick_coord(gen_side);
    // Mostly legal window pairs, so the exchange path actually runs.
    if (k == KIND_NBR && gen_side >= 3 && $urandom_range(0, 9) < 7) begin
      ra = $urandom_range(1, gen_side-2); ca = $urandom_range(1, gen_side-2);
      rb = $urandom_range(1, gen_side-2); cb = $urandom_range(1, gen_side-2);
    end
    queue_cmd(k, ra, ca, rb, cb, $urandom_range(0, 255));
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || s_axis_tvalid || result_q.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_side(int n);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= n[4:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    pred_side = n;
    gen_side  = n;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Drive requests at the falling edge; advance only after a handshake.
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || in_took) begin
      if (pending_q.size() != 0 && $urandom_range(0, 99) >= snd_idle) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, pending_q.pop_front()};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= rcv_stall);
  end

  // Check results, then predict for the request taken at this edge.
  always @(posedge clk_i) begin
    tile_res_t got, want;
    in_took <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[9:0];
      if (result_q.size() == 0) report("unexpected result", m_axis_tdata, 0);
      else begin
        want = result_q.pop_front();
        if (got.pixel !== want.pixel) report("pixel_out", got.pixel, want.pixel);
        if (got.status !== want.status) report("status", got.status, want.status);
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      result_q.push_back(tile_apply(0, s_axis_tdata[26:0], pred_side));
  end

  // Bound the run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    int sides [8] = '{7, 2, 16, 5, 3, 12, 16, 4};
    snd_idle = 0;
    rcv_stall = 0;
    pred_side = MaxSide;
    gen_side = MaxSide;
    for (int i = 0; i < StoreDepth; i++) begin
      tile_mem[0][i] = 8'd0;
      tile_mem[1][i] = 8'd0;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < 8; ph++) begin
      write_side(sides[ph]);
      case (ph % 4)
        0: begin snd_idle = 0;  rcv_stall = 0;  end
        1: begin snd_idle = 66; rcv_stall = 0;  end
        2: begin snd_idle = 0;  rcv_stall = 66; end
        default: begin snd_idle = 15; rcv_stall = 15; end
      endcase
      if (ph == 0) begin
        // Corners and extreme pixels, every kind, each reject path.
        queue_cmd(KIND_WRITE, 0, 0, 0, 0, 8'h00);
        queue_cmd(KIND_WRITE, 6, 6, 0, 0, 8'hFF);
        queue_cmd(KIND_WRITE, 0, 6, 0, 0, 8'hA5);
        queue_cmd(KIND_WRITE, 6, 0, 0, 0, 8'h5A);
        queue_cmd(KIND_WRITE, 15, 15, 0, 0, 8'h11);
        queue_cmd(KIND_READ, 6, 6, 0, 0, 0);
        queue_cmd(KIND_READ, 15, 0, 0, 0, 0);
        queue_cmd(KIND_SWAP, 0, 0, 6, 6, 0);
        queue_cmd(KIND_SWAP, 0, 0, 7, 6, 0);
        queue_cmd(KIND_COLS, 0, 0, 0, 6, 0);
        queue_cmd(KIND_COLS, 0, 15, 0, 0, 0);
        queue_cmd(KIND_MIRROR, 0, 0, 0, 0, 0);
        queue_cmd(KIND_TRANS, 0, 0, 0, 0, 0);
        queue_cmd(KIND_ROT, 0, 0, 0, 0, 0);
        queue_cmd(KIND_NBR, 1, 1, 4, 4, 0);
        queue_cmd(KIND_NBR, 5, 1, 1, 5, 0);
        queue_cmd(KIND_NBR, 0, 3, 4, 4, 0);
        queue_cmd(KIND_NBR, 2, 2, 4, 4, 0);
        queue_cmd(KIND_NBR, 2, 2, 9, 4, 0);
        queue_cmd(KIND_READ, 0, 0, 0, 0, 0);
        queue_cmd(KIND_READ, 6, 0, 0, 0, 0);
      end
      for (int i = 0; i < 175; i++) begin
        queue_random();
        // Hold off once mid-phase until the engine has drained.
        if (ph == 2 && i == 80) wait_idle();
      end
      wait_idle();
    end

    snd_idle = 0;
    rcv_stall = 0;
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/stte_pkg.sv
hw/rtl/stte_xchg.sv
hw/rtl/square_tile_transform_engine_core.sv
tb/tb.sv
